[hw/rtl/wrzg_pkg.sv]
// Shared constants for the weighted random zone gate and glide unit.
`timescale 1ns / 1ps

package wrzg_pkg;

    localparam int Q16_W   = 17;
    localparam int RAND_W  = 7;
    localparam int TIME_W  = 32;
    localparam int GATE_W  = 5;
    localparam int ZONE_W  = 3;
    localparam int ZONES   = 5;
    localparam int BOUNDS  = 4;
    localparam int PROBS   = 3;

    localparam logic [Q16_W-1:0]  Q16_ONE    = 17'h10000;
    localparam logic [RAND_W-1:0] RAND_LAST  = 7'd99;
    localparam logic [TIME_W-1:0] RAND_SCALE = 32'd100;
    localparam logic [TIME_W-1:0] CV_SCALE   = 32'd5;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

endpackage

[hw/rtl/wrzg_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module wrzg_div #(
    parameter int QUO_W = 19,
    parameter int DEN_W = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [QUO_W+DEN_W-1:0] dividend,
    input  logic [DEN_W-1:0]       divisor,
    output logic                   done,
    output logic [QUO_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[QUO_W+DEN_W-1:QUO_W];
            quo_reg <= dividend[QUO_W-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

endmodule

[hw/rtl/weighted_random_zone_gate_glide_unit.sv]
// Top level of the weighted random zone gate and glide unit.
`timescale 1ns / 1ps

// Each input beat produces exactly one result beat. The block takes one item
// at a time and drops ready until that item's result is loaded into the
// output register; a waiting result does not stop the next item from being
// accepted. A draw item is accepted, then its random value is scaled by a
// reciprocal multiplication, the zone is picked and the output register is
// loaded. For an update item, the first boundary is formed at acceptance and
// each of the other three takes a multiply step and an add step through the
// shared multiplier. The level is then set up, scaled by one fifth through a
// reciprocal multiplication and loaded into the output register. The first
// update also passes through the draw steps of scaling and zone picking.
// With glide enabled, an update adds a clamp step, the glide multiply and one
// division on the restoring divider, which yields one quotient bit per cycle
// over FRAC_BITS+3 bits; when the previous draw interval is zero, the division
// is skipped and the level goes straight to the target. A result that is not
// taken holds the next item in its last step until m_ready frees the output
// register.

module weighted_random_zone_gate_glide_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [wrzg_pkg::RAND_W-1:0]   s_random_draw,
    input  logic [wrzg_pkg::Q16_W-1:0]    s_prob_first,
    input  logic [wrzg_pkg::Q16_W-1:0]    s_prob_second,
    input  logic [wrzg_pkg::Q16_W-1:0]    s_prob_third,
    input  logic [wrzg_pkg::Q16_W-1:0]    s_prob_fourth,
    input  logic [wrzg_pkg::Q16_W-1:0]    s_zone_offset,
    input  logic [wrzg_pkg::TIME_W-1:0]   s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wrzg_pkg::Q16_W-1:0]    m_cv_level,
    output logic [wrzg_pkg::GATE_W-1:0]   m_zone_gates
);

    import wrzg_pkg::*;

    localparam int BW = FRAC_BITS + 1;
    localparam int W  = FRAC_BITS + 3;
    localparam int UP = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
    localparam int DN = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam int XW = Q16_W + UP;
    localparam int TW = W + DN;
    localparam int PW = W + TIME_W;

    localparam int R100_SH = 14;
    localparam int R100_W  = FRAC_BITS + 8;
    localparam int FP_W    = RAND_W + R100_W;
    localparam int R5_SH   = FRAC_BITS + 6;
    localparam int R5_W    = FRAC_BITS + 4;
    localparam int CP_W    = W + R5_W;

    localparam logic [BW-1:0] ONE_B    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0]  FIVE_ONE = {3'b101, {FRAC_BITS{1'b0}}};

    // Rounded-up reciprocals; the shifts leave enough guard bits that the
    // products floor to the exact quotients over the whole operand range.
    localparam logic [R100_W-1:0] RECIP_100 =
        R100_W'(((64'd1 << (FRAC_BITS + R100_SH)) + 64'(RAND_SCALE) - 64'd1) /
                64'(RAND_SCALE));
    localparam logic [R5_W-1:0] RECIP_5 =
        R5_W'(((64'd1 << R5_SH) + 64'(CV_SCALE) - 64'd1) / 64'(CV_SCALE));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_MUL,
        ST_B_ADD,
        ST_DRAW_GO,
        ST_DRAW_ZONE,
        ST_POS,
        ST_CLAMP,
        ST_G_MUL,
        ST_G_WAIT,
        ST_CV,
        ST_OUT
    } state_t;

    function automatic logic [BW-1:0] from_q16(input logic [Q16_W-1:0] v);
        logic [Q16_W-1:0] sat;
        logic [XW-1:0]    ext;
        sat = (v > Q16_ONE) ? Q16_ONE : v;
        ext = XW'(sat) << UP;
        return BW'(ext >> DN);
    endfunction

    function automatic logic [Q16_W-1:0] to_q16(input logic [W-1:0] v);
        logic [TW-1:0] sh;
        sh = (TW'(v) << DN) >> UP;
        return (sh > TW'(Q16_ONE)) ? Q16_ONE : Q16_W'(sh);
    endfunction

    state_t            state_reg;
    logic              glide_en_reg;
    logic              op_reg;
    logic [RAND_W-1:0] rnd_reg;
    logic [TIME_W-1:0] now_reg;
    logic [BW-1:0]     prob_reg [PROBS];
    logic [BW-1:0]     bounds_reg [BOUNDS];
    logic [BW-1:0]     cur_b_reg;
    logic [1:0]        k_reg;
    logic              first_pending_reg;
    logic [W-1:0]      target_reg;
    logic [W-1:0]      start_reg;
    logic [W-1:0]      glide_pos_reg;
    logic [TIME_W-1:0] draw_time_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [GATE_W-1:0] gate_bits_reg;
    logic [PW-1:0]     prod_reg;
    logic [BW-1:0]     frac_reg;
    logic              div_start_reg;
    logic [PW-1:0]     div_num_reg;
    logic [TIME_W-1:0] div_den_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] den_reg;
    logic [TIME_W-1:0] num_reg;
    logic              neg_reg;
    logic [W-1:0]      mag_reg;
    logic [Q16_W-1:0]  cv_reg;
    logic              m_valid_reg;
    logic [Q16_W-1:0]  m_cv_reg;
    logic [GATE_W-1:0] m_gates_reg;

    logic              div_done;
    logic [W-1:0]      div_quo;
    logic [BW:0]       b0_sum;
    logic [BW-1:0]     b0;
    logic [BW-1:0]     b_add;
    logic [RAND_W-1:0] rnd_sat;
    logic [W-1:0]      mul_a;
    logic [TIME_W-1:0] mul_b;
    logic [PW-1:0]     mul_prod;
    logic [FP_W-1:0]   frac_prod;
    logic [BW-1:0]     frac_w;
    logic [W-1:0]      cv_src;
    logic [CP_W-1:0]   cv_prod;
    logic [W-1:0]      cv_quo;
    logic [BW-1:0]     zone_lo [ZONES];
    logic [BW-1:0]     zone_hi [ZONES];
    logic [ZONE_W-1:0] zone_sel;
    logic              zone_hit;
    logic [TIME_W-1:0] t_clamp;
    logic [W-1:0]      glide_pos;

    wrzg_div #(
        .QUO_W(W),
        .DEN_W(TIME_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cv_level   = m_cv_reg;
    assign m_zone_gates = m_gates_reg;

    assign rnd_sat = (s_random_draw > RAND_LAST) ? RAND_LAST : s_random_draw;
    assign b0_sum  = {1'b0, from_q16(s_prob_first)} + {1'b0, from_q16(s_zone_offset)};
    assign b0      = (b0_sum > {1'b0, ONE_B}) ? BW'(b0_sum - {1'b0, ONE_B}) : BW'(b0_sum);
    assign b_add   = cur_b_reg + BW'(prod_reg >> FRAC_BITS);

    assign mul_a    = (state_reg == ST_G_MUL) ? mag_reg : W'(ONE_B - cur_b_reg);
    assign mul_b    = (state_reg == ST_G_MUL) ? num_reg : TIME_W'(prob_reg[k_reg]);
    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    assign frac_prod = FP_W'(rnd_reg) * FP_W'(RECIP_100);
    assign frac_w    = BW'(frac_prod >> R100_SH);

    assign cv_src  = glide_en_reg ? glide_pos_reg : target_reg;
    assign cv_prod = CP_W'(cv_src) * CP_W'(RECIP_5);
    assign cv_quo  = W'(cv_prod >> R5_SH);

    assign t_clamp = (t_reg < prev_time_reg) ? prev_time_reg :
                     (t_reg > draw_time_reg) ? draw_time_reg : t_reg;
    assign glide_pos = neg_reg ? (start_reg - div_quo) : (start_reg + div_quo);

    always_comb begin
        zone_lo[0]         = '0;
        zone_hi[ZONES-1]   = ONE_B;
        for (int i = 1; i < ZONES; i++) begin
            zone_lo[i] = bounds_reg[i-1];
        end
        for (int i = 0; i < BOUNDS; i++) begin
            zone_hi[i] = bounds_reg[i];
        end
    end

    always_comb begin
        zone_sel = '0;
        zone_hit = 1'b0;
        for (int z = ZONES - 1; z >= 0; z--) begin
            if (frac_reg > zone_lo[z] && frac_reg < zone_hi[z]) begin
                zone_sel = ZONE_W'(z);
                zone_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            glide_en_reg      <= 1'b0;
            first_pending_reg <= 1'b1;
            for (int i = 0; i < BOUNDS; i++) begin
                bounds_reg[i] <= '0;
            end
            target_reg        <= '0;
            start_reg         <= '0;
            glide_pos_reg     <= '0;
            draw_time_reg     <= '0;
            prev_time_reg     <= '0;
            gate_bits_reg     <= '0;
            div_start_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                glide_en_reg <= cfg_wr_data;
            end
            if (m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg  <= s_operation;
                        rnd_reg <= rnd_sat;
                        now_reg <= s_now_ms;
                        if (s_operation == OP_DRAW) begin
                            state_reg <= ST_DRAW_GO;
                        end else begin
                            prob_reg[0]   <= from_q16(s_prob_second);
                            prob_reg[1]   <= from_q16(s_prob_third);
                            prob_reg[2]   <= from_q16(s_prob_fourth);
                            bounds_reg[0] <= b0;
                            cur_b_reg     <= b0;
                            k_reg         <= '0;
                            state_reg     <= ST_B_MUL;
                        end
                    end
                end

                ST_B_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_B_ADD;
                end

                ST_B_ADD: begin
                    bounds_reg[k_reg + 2'd1] <= b_add;
                    cur_b_reg                <= b_add;
                    k_reg                    <= k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        if (first_pending_reg) begin
                            first_pending_reg <= 1'b0;
                            state_reg         <= ST_DRAW_GO;
                        end else begin
                            state_reg <= ST_POS;
                        end
                    end else begin
                        state_reg <= ST_B_MUL;
                    end
                end

                ST_DRAW_GO: begin
                    start_reg     <= glide_pos_reg;
                    prev_time_reg <= draw_time_reg;
                    draw_time_reg <= now_reg;
                    frac_reg      <= frac_w;
                    state_reg     <= ST_DRAW_ZONE;
                end

                ST_DRAW_ZONE: begin
                    if (zone_hit) begin
                        gate_bits_reg <= GATE_W'(1) << zone_sel;
                    end
                    target_reg <= (W'(zone_sel) << FRAC_BITS) + W'(frac_reg);
                    if (op_reg == OP_DRAW) begin
                        cv_reg    <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_POS;
                    end
                end

                ST_POS: begin
                    if (glide_en_reg) begin
                        t_reg     <= now_reg - (draw_time_reg - prev_time_reg);
                        den_reg   <= draw_time_reg - prev_time_reg;
                        neg_reg   <= target_reg < start_reg;
                        mag_reg   <= (target_reg < start_reg) ? (start_reg - target_reg)
                                                              : (target_reg - start_reg);
                        state_reg <= ST_CLAMP;
                    end else begin
                        state_reg <= ST_CV;
                    end
                end

                ST_CLAMP: begin
                    num_reg <= t_clamp - prev_time_reg;
                    if (den_reg == '0) begin
                        glide_pos_reg <= target_reg;
                        state_reg     <= ST_CV;
                    end else begin
                        state_reg <= ST_G_MUL;
                    end
                end

                ST_G_MUL: begin
                    div_num_reg   <= mul_prod;
                    div_den_reg   <= den_reg;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_G_WAIT;
                end

                ST_G_WAIT: begin
                    if (div_done) begin
                        glide_pos_reg <= glide_pos;
                        state_reg     <= ST_CV;
                    end
                end

                ST_CV: begin
                    cv_reg    <= to_q16(cv_quo);
                    state_reg <= ST_OUT;
                end

                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_cv_reg    <= cv_reg;
                        m_gates_reg <= gate_bits_reg;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_gates_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(gate_bits_reg))
        else $error("More than one zone gate is set.");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_G_WAIT))
        else $error("Divider finished while no state was waiting for it.");

    a_bounds_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bounds_reg[0] <= ONE_B && bounds_reg[1] <= ONE_B &&
        bounds_reg[2] <= ONE_B && bounds_reg[3] <= ONE_B)
        else $error("A zone boundary exceeds one.");

    a_levels_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        target_reg < FIVE_ONE && start_reg < FIVE_ONE && glide_pos_reg < FIVE_ONE)
        else $error("A level left the five-zone range.");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("An accepted beat did not start processing.");

endmodule

[test/testbench.sv]
// Self-checking testbench for the weighted random zone gate and glide unit.
`timescale 1ns / 1ps

module testbench;
    import wrzg_pkg::*;

    localparam int DIRECTED_COUNT = 25;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 220;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 40;
    localparam longint unsigned UNITY = 65536;

    typedef struct {
        bit                  glide;
        logic                op;
        logic [RAND_W-1:0]   rnd;
        logic [Q16_W-1:0]    p1;
        logic [Q16_W-1:0]    p2;
        logic [Q16_W-1:0]    p3;
        logic [Q16_W-1:0]    p4;
        logic [Q16_W-1:0]    off;
        logic [TIME_W-1:0]   now;
        bit                  typed;
        logic [Q16_W-1:0]    cv;
        logic [GATE_W-1:0]   gates;
    } zone_item_t;

    typedef struct packed {
        bit [Q16_W-1:0]  cv;
        bit [GATE_W-1:0] gates;
    } zone_beat_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic                s_operation;
    logic [RAND_W-1:0]   s_random_draw;
    logic [Q16_W-1:0]    s_prob_first;
    logic [Q16_W-1:0]    s_prob_second;
    logic [Q16_W-1:0]    s_prob_third;
    logic [Q16_W-1:0]    s_prob_fourth;
    logic [Q16_W-1:0]    s_zone_offset;
    logic [TIME_W-1:0]   s_now_ms;
    logic                m_valid;
    logic                m_ready;
    logic [Q16_W-1:0]    m_cv_level;
    logic [GATE_W-1:0]   m_zone_gates;

    bit [Q16_W-1:0]  bound_q [BOUNDS] = '{0, 0, 0, 0};
    bit              first_q = 1'b1;
    bit [18:0]       target_q = '0;
    bit [18:0]       start_q = '0;
    bit [18:0]       glide_pos_q = '0;
    bit [TIME_W-1:0] draw_time_q = '0;
    bit [TIME_W-1:0] prev_draw_q = '0;
    bit [GATE_W-1:0] gates_q = '0;
    bit              glide_on = 1'b0;

    zone_beat_t pending_beats [$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int edge_rnd = -1;
    bit [TIME_W-1:0] clock_ms = '0;

    int phase_idle [PHASES] = '{0, 56, 0, 12, 0};
    int phase_stall [PHASES] = '{0, 0, 56, 12, 0};
    bit phase_glide [PHASES] = '{0, 1, 0, 1, 1};

    zone_item_t directed_items [DIRECTED_COUNT] = '{
        '{0, OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{0, OP_DRAW, 99, 0, 0, 0, 0, 0, 10, 1, 0, 16},
        '{0, OP_DRAW, 0, 0, 0, 0, 0, 0, 20, 1, 0, 16},
        '{0, OP_UPDATE, 0, 65536, 0, 0, 0, 0, 30, 0, 0, 0},
        '{0, OP_DRAW, 50, 0, 0, 0, 0, 0, 40, 1, 0, 1},
        '{0, OP_UPDATE, 0, 131071, 0, 0, 0, 131071, 50, 1, 6553, 1},
        '{0, OP_DRAW, 127, 0, 0, 0, 0, 0, 60, 1, 0, 1},
        '{0, OP_UPDATE, 3, 30000, 65536, 0, 131071, 50000, 70, 0, 0, 0},
        '{0, OP_UPDATE, 0, 16384, 0, 0, 0, 0, 80, 0, 0, 0},
        '{0, OP_DRAW, 25, 0, 0, 0, 0, 0, 90, 0, 0, 0},
        '{0, OP_DRAW, 75, 0, 0, 0, 0, 0, 100, 0, 0, 0},
        '{0, OP_UPDATE, 0, 40000, 20000, 65535, 1, 65536, 110, 0, 0, 0},
        '{1, OP_DRAW, 10, 0, 0, 0, 0, 0, 1000, 0, 0, 0},
        '{1, OP_DRAW, 90, 0, 0, 0, 0, 0, 3000, 0, 0, 0},
        '{1, OP_UPDATE, 0, 20000, 30000, 40000, 50000, 10000, 2000, 0, 0, 0},
        '{1, OP_UPDATE, 0, 20000, 30000, 40000, 50000, 10000, 3500, 0, 0, 0},
        '{1, OP_UPDATE, 0, 20000, 30000, 40000, 50000, 10000, 9000, 0, 0, 0},
        '{1, OP_DRAW, 40, 0, 0, 0, 0, 0, 9000, 0, 0, 0},
        '{1, OP_DRAW, 60, 0, 0, 0, 0, 0, 9000, 0, 0, 0},
        '{1, OP_UPDATE, 0, 5000, 5000, 5000, 5000, 0, 9500, 0, 0, 0},
        '{1, OP_DRAW, 5, 0, 0, 0, 0, 0, 32'hFFFF_FF00, 0, 0, 0},
        '{1, OP_DRAW, 95, 0, 0, 0, 0, 0, 256, 0, 0, 0},
        '{1, OP_UPDATE, 0, 1000, 2000, 3000, 4000, 500, 0, 0, 0, 0},
        '{1, OP_UPDATE, 127, 131071, 131071, 131071, 131071, 0, 32'hFFFF_FFFF, 0, 0, 0},
        '{0, OP_UPDATE, 127, 65536, 65536, 65536, 65536, 65536, 32'hFFFF_FFFF, 0, 0, 0}
    };

    weighted_random_zone_gate_glide_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_random_draw (s_random_draw),
        .s_prob_first  (s_prob_first),
        .s_prob_second (s_prob_second),
        .s_prob_third  (s_prob_third),
        .s_prob_fourth (s_prob_fourth),
        .s_zone_offset (s_zone_offset),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cv_level    (m_cv_level),
        .m_zone_gates  (m_zone_gates)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned q16_sat(bit [Q16_W-1:0] v);
        return (v > Q16_ONE) ? UNITY : longint'(v);
    endfunction

    task automatic draw_zone(input bit [RAND_W-1:0] rnd, input bit [TIME_W-1:0] now);
        longint unsigned pick, frac, lo, hi;
        int zone;
        bit hit;
        start_q = glide_pos_q;
        prev_draw_q = draw_time_q;
        draw_time_q = now;
        pick = (rnd > RAND_LAST) ? longint'(RAND_LAST) : longint'(rnd);
        frac = (pick * UNITY) / RAND_SCALE;
        zone = 0;
        hit = 1'b0;
        for (int k = 0; k < ZONES; k++) begin
            lo = 0;
            hi = UNITY;
            if (k > 0) lo = bound_q[k-1];
            if (k < BOUNDS) hi = bound_q[k];
            if (!hit && frac > lo && frac < hi) begin
                zone = k;
                gates_q = GATE_W'(1 << k);
                hit = 1'b1;
            end
        end
        target_q = 19'(frac + longint'(zone) * UNITY);
    endtask

    function automatic bit [18:0] glide_level(bit [TIME_W-1:0] now);
        bit [TIME_W-1:0] span, t, num, den;
        longint delta;
        span = draw_time_q - prev_draw_q;
        t = now - span;
        if (t < prev_draw_q) t = prev_draw_q;
        else if (t > draw_time_q) t = draw_time_q;
        num = t - prev_draw_q;
        den = draw_time_q - prev_draw_q;
        if (den == 0) return target_q;
        delta = longint'(target_q) - longint'(start_q);
        delta = (delta * longint'(num)) / longint'(den);
        return 19'(longint'(start_q) + delta);
    endfunction

    task automatic predict_beat(input zone_item_t it, output bit [Q16_W-1:0] cv,
                                output bit [GATE_W-1:0] gates);
        longint unsigned b, pos;
        bit [Q16_W-1:0] shares [PROBS];
        shares[0] = it.p2;
        shares[1] = it.p3;
        shares[2] = it.p4;
        if (it.op == OP_DRAW) begin
            draw_zone(it.rnd, it.now);
            cv = '0;
        end else begin
            b = q16_sat(it.p1) + q16_sat(it.off);
            if (b > UNITY) b = b - UNITY;
            bound_q[0] = Q16_W'(b);
            for (int k = 1; k < BOUNDS; k++) begin
                b = b + ((q16_sat(shares[k-1]) * (UNITY - b)) >> 16);
                bound_q[k] = Q16_W'(b);
            end
            if (first_q) begin
                draw_zone(it.rnd, it.now);
                first_q = 1'b0;
            end
            if (glide_on) begin
                glide_pos_q = glide_level(it.now);
                pos = glide_pos_q;
            end else begin
                pos = target_q;
            end
            pos = pos / CV_SCALE;
            cv = (pos > UNITY) ? Q16_ONE : Q16_W'(pos);
        end
        gates = gates_q;
    endtask

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        if (errors < MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_beats.size() != 0);
    endtask

    task automatic set_glide(input bit value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        glide_on = value;
    endtask

    task automatic send_item(input zone_item_t it);
        zone_beat_t beat;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= it.op;
        s_random_draw <= it.rnd;
        s_prob_first <= it.p1;
        s_prob_second <= it.p2;
        s_prob_third <= it.p3;
        s_prob_fourth <= it.p4;
        s_zone_offset <= it.off;
        s_now_ms <= it.now;
        do @(posedge aclk); while (!s_ready);
        predict_beat(it, beat.cv, beat.gates);
        if (it.typed) begin
            beat.cv = it.cv;
            beat.gates = it.gates;
        end
        pending_beats.push_back(beat);
    endtask

    function automatic bit [Q16_W-1:0] random_q16();
        case ($urandom_range(9))
            0: return '0;
            1: return Q16_ONE;
            2: return Q16_W'($urandom_range(131071, 65537));
            default: return Q16_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic make_random_item(output zone_item_t it);
        int r;
        it.glide = glide_on;
        it.typed = 1'b0;
        it.cv = '0;
        it.gates = '0;
        it.op = ($urandom_range(99) < 55) ? OP_DRAW : OP_UPDATE;
        it.rnd = ($urandom_range(9) == 0) ? RAND_W'($urandom_range(127, 100))
                                          : RAND_W'($urandom_range(99));
        it.p1 = random_q16();
        it.p2 = random_q16();
        it.p3 = random_q16();
        it.p4 = random_q16();
        it.off = random_q16();
        if (it.op == OP_DRAW && edge_rnd >= 0) begin
            it.rnd = RAND_W'(edge_rnd);
            edge_rnd = -1;
        end else if (it.op == OP_UPDATE && $urandom_range(9) == 0) begin
            r = $urandom_range(99);
            it.p1 = Q16_W'((r * 65536) / 100);
            it.off = '0;
            edge_rnd = r;
        end
        case ($urandom_range(9))
            0: clock_ms = $urandom;
            1: clock_ms = 32'hFFFF_FFFF - $urandom_range(2000);
            2: clock_ms = clock_ms;
            default: clock_ms = clock_ms + $urandom_range(3000, 1);
        endcase
        it.now = clock_ms;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        zone_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch("unexpected beat, cv", 0, m_cv_level);
            end else begin
                want = pending_beats.pop_front();
                if (m_cv_level !== want.cv) flag_mismatch("cv_level", want.cv, m_cv_level);
                if (m_zone_gates !== want.gates)
                    flag_mismatch("zone_gates", want.gates, m_zone_gates);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        zone_item_t item;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_UPDATE;
        s_random_draw <= '0;
        s_prob_first <= '0;
        s_prob_second <= '0;
        s_prob_third <= '0;
        s_prob_fourth <= '0;
        s_zone_offset <= '0;
        s_now_ms <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        set_glide(1'b0);
        foreach (directed_items[i]) begin
            if (directed_items[i].glide != glide_on) set_glide(directed_items[i].glide);
            send_item(directed_items[i]);
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            set_glide(phase_glide[ph]);
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) wait_drained();
                make_random_item(item);
                send_item(item);
            end
        end
        wait_drained();
        repeat (100) @(posedge aclk);
        if (pending_beats.size() != 0) flag_mismatch("beats left over", 0, pending_beats.size());
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wrzg_pkg.sv
hw/rtl/wrzg_div.sv
hw/rtl/weighted_random_zone_gate_glide_unit.sv
test/testbench.sv
